// ===== rtl/core/gmps_pkg.sv =====
// ----------------------------------------------------------------------------
// gmps_pkg: shared constants and types for the grid minimum path sum unit
// Widths, limits, register indexes and the position flags passed from the
// sequencer to the datapath.
// ----------------------------------------------------------------------------
package gmps_pkg;

	localparam int MAX_COLUMNS_DEF = 1024;
	localparam int CELL_BITS_DEF   = 16;

	localparam int CELL_W    = 16;
	localparam int SUM_W     = 32;
	localparam int CNT_W     = 11;
	localparam int ROW_W     = 10;
	localparam int ROW_LIMIT = 1024;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef struct packed {
		logic first_row;
		logic first_col;
		logic last_cell;
	} pos_flags_t;

endpackage

// ===== rtl/core/gmps_cell_if.sv =====
// ----------------------------------------------------------------------------
// gmps_cell_if: grid cell stream
// Valid/ready channel carrying one grid cell value per transaction.
// ----------------------------------------------------------------------------
interface gmps_cell_if;
	logic                        valid;
	logic                        ready;
	logic [gmps_pkg::CELL_W-1:0] cell_value;

	modport source (output valid, output cell_value, input ready);
	modport sink   (input valid, input cell_value, output ready);
endinterface

// ===== rtl/core/gmps_result_if.sv =====
// ----------------------------------------------------------------------------
// gmps_result_if: path sum result stream
// Valid/ready channel carrying one grid result per transaction.
// ----------------------------------------------------------------------------
interface gmps_result_if;
	logic                       valid;
	logic                       ready;
	logic [gmps_pkg::SUM_W-1:0] path_sum;
	logic                       saturated;

	modport source (output valid, output path_sum, output saturated, input ready);
	modport sink   (input valid, input path_sum, input saturated, output ready);
endinterface

// ===== rtl/core/gmps_cfg_if.sv =====
// ----------------------------------------------------------------------------
// gmps_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface gmps_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [gmps_pkg::CFG_IDX_W-1:0] index;
	logic [gmps_pkg::CNT_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/gmps_seq.sv =====
// ----------------------------------------------------------------------------
// gmps_seq: grid position sequencer
// Tracks row and column of the next cell and flags first row, first column
// and last cell against the clamped grid dimensions.
// ----------------------------------------------------------------------------
module gmps_seq #(
	parameter int MAX_COLUMNS = gmps_pkg::MAX_COLUMNS_DEF,
	parameter int COL_W       = 10,
	parameter int CNT_W       = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [gmps_pkg::CNT_W-1:0] row_count,
	input  logic [gmps_pkg::CNT_W-1:0] column_count,
	input  logic                       accept,
	output logic [COL_W-1:0]           col,
	output gmps_pkg::pos_flags_t       flags
);

	logic [gmps_pkg::ROW_W-1:0] row_q;
	logic [COL_W-1:0]           col_q;
	logic [CNT_W-1:0]           cc_ext;
	logic [CNT_W-1:0]           cols;
	logic [CNT_W-1:0]           col_next;
	logic [gmps_pkg::CNT_W-1:0] rows;
	logic [gmps_pkg::CNT_W-1:0] row_next;
	logic                       last_col;
	logic                       last_row;

	always_comb begin
		cc_ext = CNT_W'(column_count);
		if (cc_ext == '0) begin
			cols = CNT_W'(1);
		end else if (cc_ext > CNT_W'(MAX_COLUMNS)) begin
			cols = CNT_W'(MAX_COLUMNS);
		end else begin
			cols = cc_ext;
		end
		if (row_count == '0) begin
			rows = gmps_pkg::CNT_W'(1);
		end else if (row_count > gmps_pkg::CNT_W'(gmps_pkg::ROW_LIMIT)) begin
			rows = gmps_pkg::CNT_W'(gmps_pkg::ROW_LIMIT);
		end else begin
			rows = row_count;
		end
		col_next = CNT_W'(col_q) + CNT_W'(1);
		row_next = gmps_pkg::CNT_W'(row_q) + gmps_pkg::CNT_W'(1);
		last_col = (col_next >= cols);
		last_row = (row_next >= rows);
	end

	assign col             = col_q;
	assign flags.first_row = (row_q == '0);
	assign flags.first_col = (col_q == '0);
	assign flags.last_cell = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q <= '0;
				end else begin
					row_q <= row_next[gmps_pkg::ROW_W-1:0];
				end
			end else begin
				col_q <= col_next[COL_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/core/gmps_dp.sv =====
// ----------------------------------------------------------------------------
// gmps_dp: row store and path sum datapath
// Reads the row store for the incoming cell, then adds the cell to the
// smaller neighbor sum, writes the partial sum back and registers results.
// ----------------------------------------------------------------------------
module gmps_dp #(
	parameter int MAX_COLUMNS = gmps_pkg::MAX_COLUMNS_DEF,
	parameter int CELL_BITS   = gmps_pkg::CELL_BITS_DEF,
	parameter int COL_W       = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	output logic                        in_ready,
	input  logic [gmps_pkg::CELL_W-1:0] cell_value,
	input  logic [COL_W-1:0]            col,
	input  gmps_pkg::pos_flags_t        flags,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gmps_pkg::SUM_W-1:0]  path_sum,
	output logic                        saturated
);

	localparam int CELL_USE = (CELL_BITS < gmps_pkg::CELL_W) ? CELL_BITS : gmps_pkg::CELL_W;

	logic [gmps_pkg::SUM_W-1:0] mem [MAX_COLUMNS];

	logic                       valid_s1;
	logic [COL_W-1:0]           col_s1;
	gmps_pkg::pos_flags_t       flags_s1;
	logic [CELL_USE-1:0]        cell_s1;
	logic                       fwd_s1;
	logic [gmps_pkg::SUM_W-1:0] rdata_s1;

	logic [gmps_pkg::SUM_W-1:0] last_q;
	logic                       ovf_q;
	logic                       out_valid_q;
	logic [gmps_pkg::SUM_W-1:0] path_sum_q;
	logic                       saturated_q;

	logic [gmps_pkg::SUM_W-1:0] above;
	logic [gmps_pkg::SUM_W-1:0] best;
	logic [gmps_pkg::SUM_W:0]   sum;
	logic                       sat;
	logic [gmps_pkg::SUM_W-1:0] value;
	logic                       s1_fire;

	always_comb begin
		above = fwd_s1 ? last_q : rdata_s1;
		if (flags_s1.first_row && flags_s1.first_col) begin
			best = '0;
		end else if (flags_s1.first_row) begin
			best = last_q;
		end else if (flags_s1.first_col) begin
			best = above;
		end else begin
			best = (above < last_q) ? above : last_q;
		end
		sum   = {1'b0, best} + (gmps_pkg::SUM_W + 1)'(cell_s1);
		sat   = sum[gmps_pkg::SUM_W];
		value = sat ? gmps_pkg::SUM_MAX : sum[gmps_pkg::SUM_W-1:0];
	end

	assign s1_fire   = valid_s1 && (!flags_s1.last_cell || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || s1_fire;
	assign out_valid = out_valid_q;
	assign path_sum  = path_sum_q;
	assign saturated = saturated_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_s1 <= mem[col];
			col_s1   <= col;
			flags_s1 <= flags;
			cell_s1  <= cell_value[CELL_USE-1:0];
			fwd_s1   <= valid_s1 && (col_s1 == col);
		end
		if (s1_fire) begin
			mem[col_s1] <= value;
			last_q      <= value;
		end
		if (s1_fire && flags_s1.last_cell) begin
			path_sum_q  <= value;
			saturated_q <= ovf_q || sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				ovf_q <= flags_s1.last_cell ? 1'b0 : (ovf_q || sat);
			end
			if (s1_fire && flags_s1.last_cell) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_fwd_same_col: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s1_fire && (col_s1 == col)) |=> fwd_s1)
		else $error("row store forward missed for back-to-back same column");

	a_hold_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && flags_s1.last_cell && out_valid_q && !out_ready) |-> !in_ready)
		else $error("cell accepted while final cell blocked by pending result");

	a_ovf_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && flags_s1.last_cell) |=> (!ovf_q && out_valid_q))
		else $error("grid end did not post result and clear overflow");
`endif

endmodule

// ===== rtl/core/grid_min_path_sum_unit.sv =====
// ----------------------------------------------------------------------------
// grid_min_path_sum_unit: streaming minimum path sum over a configured grid
// Top level with configuration registers, position sequencer and datapath.
// ----------------------------------------------------------------------------
// Cells enter in row-major order at one per clock with no gaps required; a
// cell's row store entry (MAX_COLUMNS x 32-bit memory, one read and one write
// port) is read at the edge that accepts it, and its sum is formed in the
// add/compare stage that follows, so the grid result is registered in the
// output register when the last cell leaves that stage. A one-column grid
// reads the entry that the previous cell writes at the same edge, which is
// forwarded from the last computed sum. Input stalls only when a grid's last
// cell is ready while the previous result is still not taken. The row store
// needs no clearing after reset. Write row_count and column_count only while
// no grid is in progress.
module grid_min_path_sum_unit #(
	parameter int MAX_COLUMNS = gmps_pkg::MAX_COLUMNS_DEF,
	parameter int CELL_BITS   = gmps_pkg::CELL_BITS_DEF
) (
	input logic            clk,
	input logic            arst_n,
	gmps_cfg_if.sink       cfg,
	gmps_cell_if.sink      cells,
	gmps_result_if.source  results
);

	localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CNT_W = (COL_W + 1 > gmps_pkg::CNT_W) ? COL_W + 1 : gmps_pkg::CNT_W;

	logic [gmps_pkg::CNT_W-1:0] row_count_q;
	logic [gmps_pkg::CNT_W-1:0] column_count_q;
	logic                       accept;
	logic                       in_ready;
	logic [COL_W-1:0]           col;
	gmps_pkg::pos_flags_t       flags;

	assign cfg.ready   = 1'b1;
	assign cells.ready = in_ready;
	assign accept      = cells.valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= gmps_pkg::CNT_W'(1);
			column_count_q <= gmps_pkg::CNT_W'(1);
		end else if (cfg.valid) begin
			if (cfg.index == gmps_pkg::REG_ROW_COUNT) begin
				row_count_q <= cfg.data;
			end else if (cfg.index == gmps_pkg::REG_COLUMN_COUNT) begin
				column_count_q <= cfg.data;
			end
		end
	end

	gmps_seq #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.COL_W       (COL_W),
		.CNT_W       (CNT_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.row_count    (row_count_q),
		.column_count (column_count_q),
		.accept       (accept),
		.col          (col),
		.flags        (flags)
	);

	gmps_dp #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.CELL_BITS   (CELL_BITS),
		.COL_W       (COL_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_ready   (in_ready),
		.cell_value (cells.cell_value),
		.col        (col),
		.flags      (flags),
		.out_valid  (results.valid),
		.out_ready  (results.ready),
		.path_sum   (results.path_sum),
		.saturated  (results.saturated)
	);

endmodule
